// File: rtl/iac_pkg.sv
// Shared definitions for the intrusion alarm controller: mode and message codes,
// register map, keypad characters and reset values.
// No dependencies; used by intrusion_alarm_controller.sv.
`default_nettype none

package iac_pkg;

    // Operating modes, as reported on mode_now.
    localparam logic [2:0] MODE_WAIT   = 3'd0;
    localparam logic [2:0] MODE_ARMING = 3'd1;
    localparam logic [2:0] MODE_ARMED  = 3'd2;
    localparam logic [2:0] MODE_ENTRY  = 3'd3;
    localparam logic [2:0] MODE_ALARM  = 3'd4;

    // Display message indexes, as reported on lcd_message.
    localparam logic [2:0] MSG_NONE      = 3'd0;
    localparam logic [2:0] MSG_PROMPT    = 3'd1;
    localparam logic [2:0] MSG_ARMING    = 3'd2;
    localparam logic [2:0] MSG_ARMED     = 3'd3;
    localparam logic [2:0] MSG_DISARMING = 3'd4;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_DELAY_TICKS   = 3'd0;
    localparam logic [2:0] REG_HIGH_TEMP     = 3'd1;
    localparam logic [2:0] REG_CODE_ZERO     = 3'd2;
    localparam logic [2:0] REG_CODE_ONE      = 3'd3;
    localparam logic [2:0] REG_CODE_TWO      = 3'd4;
    localparam logic [2:0] REG_CODE_THREE    = 3'd5;
    localparam logic [2:0] REG_CODES_ENABLED = 3'd6;

    localparam int ADDR_W      = 5;
    localparam int CODE_W      = 14;
    localparam int COUNT_W     = 16;
    localparam int CODE_REGS   = 4;
    localparam int NUM_CODES_DEFAULT = 4;

    // Reset values of the configuration registers.
    localparam logic [15:0]     DELAY_TICKS_RESET   = 16'd10000;
    localparam logic [7:0]      HIGH_TEMP_RESET     = 8'd30;
    localparam logic [2:0]      CODES_ENABLED_RESET = 3'd1;

    // Keypad characters.
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_HASH = 8'h23;

    // Seconds split: x * SEC_RECIP >> SEC_SHIFT is x / 1000 for any 16-bit x.
    // The fraction bits [25:16] are all zero exactly when x is a multiple of 1000.
    localparam logic [16:0] SEC_RECIP = 17'd67109;
    localparam int          SEC_SHIFT = 26;

endpackage

`default_nettype wire

// File: rtl/intrusion_alarm_controller.sv
// Intrusion alarm controller top level: stream input and result channels,
// APB configuration port and the mode sequencer. Depends on iac_pkg.
// Throughput is one tick item per clock when not stalled; items cross the input
// register, then the result register. Each tick item carries the optional key
// character in tdata with its presence flag in tuser. A four-digit code is
// collected over consecutive digit keys and checked against the enabled stored
// codes on the fourth digit. The arming and entry countdowns run for delay_ticks
// items; the seconds display refreshes on every 1000-tick boundary. The path that
// sets the clock rate is the constant multiply splitting the countdown into seconds
// for seconds_left. Configuration is to be written only while no tick is in flight;
// the block does not enforce this. No clearing pass is needed after reset.
`default_nettype none

module intrusion_alarm_controller #(
    parameter int NUM_CODES = iac_pkg::NUM_CODES_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Tick input channel.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,   // key_char[7:0], switch_bits[15:8],
                                                      // temperature[23:16]
    input  wire logic                      s_tuser,   // key_present[0]
    // Result channel.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [15:0]                    m_tdata,   // mode_now[2:0], siren_on[3],
                                                      // lcd_message[6:4], digits_update[7],
                                                      // seconds_left[14:8],
                                                      // temperature_shown[15]
    // Configuration port.
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [iac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int STORED_CODES =
        (NUM_CODES < iac_pkg::CODE_REGS) ? NUM_CODES : iac_pkg::CODE_REGS;
    localparam int CW = iac_pkg::CODE_W;
    localparam int NW = iac_pkg::COUNT_W;

    // Configuration registers.
    logic [NW-1:0] delay_ticks_reg;
    logic [7:0]    high_temp_reg;
    logic [CW-1:0] code_reg [STORED_CODES];
    logic [2:0]    codes_enabled_reg;

    // Controller state.
    logic [2:0]    mode_reg,       mode_next;
    logic [NW-1:0] countdown_reg,  countdown_next;
    logic [CW-1:0] acc_reg,        acc_next;
    logic [1:0]    digits_reg,     digits_next;

    // Input and result registers.
    logic          in_valid_reg;
    logic [23:0]   in_data_reg;
    logic          in_present_reg;
    logic          out_valid_reg;
    logic [15:0]   out_data_reg,   out_data_next;

    logic          advance;
    logic          cfg_write;
    logic [2:0]    cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg   <= iac_pkg::DELAY_TICKS_RESET;
            high_temp_reg     <= iac_pkg::HIGH_TEMP_RESET;
            codes_enabled_reg <= iac_pkg::CODES_ENABLED_RESET;
            for (int i = 0; i < STORED_CODES; i++) begin
                code_reg[i] <= '0;
            end
        end else if (cfg_write) begin
            if (cfg_index == iac_pkg::REG_DELAY_TICKS) begin
                delay_ticks_reg <= pwdata[NW-1:0];
            end
            if (cfg_index == iac_pkg::REG_HIGH_TEMP) begin
                high_temp_reg <= pwdata[7:0];
            end
            if (cfg_index == iac_pkg::REG_CODES_ENABLED) begin
                codes_enabled_reg <= pwdata[2:0];
            end
            for (int i = 0; i < STORED_CODES; i++) begin
                if (cfg_index == 3'(int'(iac_pkg::REG_CODE_ZERO) + i)) begin
                    code_reg[i] <= pwdata[CW-1:0];
                end
            end
        end
    end

    // Register readback.
    always_comb begin
        prdata = '0;
        case (cfg_index)
            iac_pkg::REG_DELAY_TICKS:   prdata = {16'd0, delay_ticks_reg};
            iac_pkg::REG_HIGH_TEMP:     prdata = {24'd0, high_temp_reg};
            iac_pkg::REG_CODES_ENABLED: prdata = {29'd0, codes_enabled_reg};
            default: begin
                for (int i = 0; i < STORED_CODES; i++) begin
                    if (cfg_index == 3'(int'(iac_pkg::REG_CODE_ZERO) + i)) begin
                        prdata = {{(32 - CW){1'b0}}, code_reg[i]};
                    end
                end
            end
        endcase
    end

    // Handshake: the input register moves on whenever the result register is
    // empty or being drained, so a request can enter every cycle unless the result side stalls.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg    <= s_tdata;
            in_present_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Fields of the held request.
    logic [7:0] key_char;
    logic [7:0] switch_bits;
    logic [7:0] temperature;
    logic       hot;
    logic       is_digit;
    logic       is_filtered;

    assign key_char    = in_data_reg[7:0];
    assign switch_bits = in_data_reg[15:8];
    assign temperature = in_data_reg[23:16];
    assign hot         = temperature >= high_temp_reg;
    assign is_digit    = key_char >= iac_pkg::ASCII_ZERO && key_char <= iac_pkg::ASCII_NINE;
    assign is_filtered = is_digit || key_char == iac_pkg::ASCII_HASH;

    // Code collector arithmetic and the parallel compare on the fourth digit.
    logic [CW+3:0] acc_value;
    logic          code_match;
    logic          collect_fire;

    assign acc_value = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                     + {{CW{1'b0}}, key_char[3:0]};

    always_comb begin
        code_match = 1'b0;
        for (int i = 0; i < STORED_CODES; i++) begin
            if ((i == 0 || codes_enabled_reg > 3'(i))
                    && acc_value == {4'd0, code_reg[i]}) begin
                code_match = 1'b1;
            end
        end
    end

    assign collect_fire = is_digit && digits_reg == 2'd3 && code_match;

    // Seconds split of the countdown.
    logic [NW+16:0] sec_product;
    logic [6:0]     sec_quotient;
    logic           sec_boundary;

    assign sec_product  = {17'd0, countdown_reg} * {{NW{1'b0}}, iac_pkg::SEC_RECIP};
    assign sec_quotient = sec_product[iac_pkg::SEC_SHIFT +: 7];
    assign sec_boundary = sec_product[25:16] == '0;

    // Mode sequencer for one tick.
    logic       do_collect;
    logic       valid_code;
    logic [2:0] msg;
    logic       upd;
    logic [6:0] secs;

    always_comb begin
        case (mode_reg)
            iac_pkg::MODE_ARMING,
            iac_pkg::MODE_ARMED,
            iac_pkg::MODE_ALARM: do_collect = in_present_reg && is_filtered;
            iac_pkg::MODE_ENTRY: do_collect = in_present_reg && is_filtered
                                              && countdown_reg != '0;
            default:             do_collect = in_present_reg;
        endcase
        valid_code = do_collect && collect_fire;

        // Collector state.
        acc_next    = acc_reg;
        digits_next = digits_reg;
        if (do_collect) begin
            if (is_digit && digits_reg != 2'd3) begin
                acc_next    = acc_value[CW-1:0];
                digits_next = digits_reg + 2'd1;
            end else begin
                acc_next    = '0;
                digits_next = '0;
            end
        end

        mode_next      = mode_reg;
        countdown_next = countdown_reg;
        msg            = iac_pkg::MSG_NONE;
        upd            = 1'b0;
        secs           = '0;

        case (mode_reg)
            iac_pkg::MODE_ARMING: begin
                if (countdown_reg != '0 && sec_boundary) begin
                    upd  = 1'b1;
                    secs = sec_quotient;
                end
                if (valid_code) begin
                    mode_next = iac_pkg::MODE_WAIT;
                    msg       = iac_pkg::MSG_PROMPT;
                end else if (countdown_reg <= NW'(1)) begin
                    countdown_next = '0;
                    mode_next      = iac_pkg::MODE_ARMED;
                    msg            = iac_pkg::MSG_ARMED;
                end else begin
                    countdown_next = countdown_reg - NW'(1);
                end
            end
            iac_pkg::MODE_ARMED: begin
                if (do_collect) begin
                    if (valid_code) begin
                        mode_next = iac_pkg::MODE_WAIT;
                        msg       = iac_pkg::MSG_PROMPT;
                    end
                end else if (switch_bits[0]) begin
                    mode_next      = iac_pkg::MODE_ENTRY;
                    msg            = iac_pkg::MSG_DISARMING;
                    countdown_next = delay_ticks_reg;
                end else if (switch_bits[7:1] != '0) begin
                    mode_next = iac_pkg::MODE_ALARM;
                    msg       = iac_pkg::MSG_NONE;
                end
                // Over temperature wins unless the entry delay just started.
                if (hot && mode_next != iac_pkg::MODE_ENTRY) begin
                    mode_next = iac_pkg::MODE_ALARM;
                    msg       = iac_pkg::MSG_NONE;
                end
            end
            iac_pkg::MODE_ENTRY: begin
                if (sec_boundary) begin
                    upd  = 1'b1;
                    secs = sec_quotient;
                end
                if (countdown_reg == '0) begin
                    mode_next = iac_pkg::MODE_ALARM;
                end else if (valid_code) begin
                    if (hot) begin
                        mode_next = iac_pkg::MODE_ALARM;
                    end else begin
                        mode_next = iac_pkg::MODE_WAIT;
                        msg       = iac_pkg::MSG_PROMPT;
                    end
                end else begin
                    countdown_next = countdown_reg - NW'(1);
                end
            end
            iac_pkg::MODE_ALARM: begin
                if (valid_code) begin
                    mode_next = iac_pkg::MODE_WAIT;
                    msg       = iac_pkg::MSG_PROMPT;
                end
            end
            default: begin
                // Waiting for a code; unused mode values behave the same.
                if (valid_code) begin
                    mode_next      = iac_pkg::MODE_ARMING;
                    msg            = iac_pkg::MSG_ARMING;
                    countdown_next = delay_ticks_reg;
                end else begin
                    mode_next = iac_pkg::MODE_WAIT;
                end
            end
        endcase

        out_data_next = {
            !(mode_next == iac_pkg::MODE_ARMING || mode_next == iac_pkg::MODE_ENTRY),
            secs,
            upd,
            msg,
            mode_next == iac_pkg::MODE_ALARM,
            mode_next
        };
    end

    // State update once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= iac_pkg::MODE_WAIT;
            countdown_reg <= '0;
            acc_reg       <= '0;
            digits_reg    <= '0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
            acc_reg       <= acc_next;
            digits_reg    <= digits_next;
        end
    end

`ifndef SYNTH
    // The siren follows the reported mode.
    a_siren_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == iac_pkg::MODE_ALARM)))
        else $error("siren_on disagrees with mode_now");

    // Seconds are only reported with a display refresh.
    a_secs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[7]) |-> (m_tdata[14:8] == 7'd0))
        else $error("seconds_left nonzero without digits_update");

    // The arming message is only given on entry to the arming countdown.
    a_arming_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6:4] == iac_pkg::MSG_ARMING)
            |-> (m_tdata[2:0] == iac_pkg::MODE_ARMING && !m_tdata[15]))
        else $error("arming message outside arming mode");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for intrusion_alarm_controller: drives keypad ticks with random
// gaps, predicts each panel status in step with the block and compares every result.
// Depends on iac_pkg and the intrusion_alarm_controller RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    // Fields of one tick request from the highest bit down (present is tuser, the rest tdata).
    typedef struct packed {
        logic       present;
        logic [7:0] temp;
        logic [7:0] switches;
        logic [7:0] key;
    } tick_t;

    // Panel status as packed on m_tdata (mode in the lowest bits).
    typedef struct packed {
        logic       shown;
        logic [6:0] secs;
        logic       upd;
        logic [2:0] msg;
        logic       siren;
        logic [2:0] mode;
    } status_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;   // key_char[7:0], switch_bits[15:8], temperature[23:16]
    logic                s_tuser;   // key_present[0]
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;   // mode_now[2:0], siren_on[3], lcd_message[6:4],
                                    // digits_update[7], seconds_left[14:8],
                                    // temperature_shown[15]
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [iac_pkg::ADDR_W-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    intrusion_alarm_controller uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted panel state and its copy of the settings.
    logic [2:0]   panel_mode;
    logic [15:0]  panel_count;
    int           code_sum;
    int           code_len;
    logic [15:0]  set_delay;
    logic [7:0]   set_threshold;
    logic [13:0]  set_codes [iac_pkg::CODE_REGS];
    logic [2:0]   set_enabled;

    status_t      pending_status [$];
    int           mode_visits [5];
    int           ticks_sent;
    int           reg_writes;
    int           results_seen;
    int           mismatches;
    int           cycle_count;
    bit           steady;

    // Clock and run limit.
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb: cycle limit reached with %0d results outstanding",
                     pending_status.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    // Number of stored codes that take part in a compare.
    function automatic int enabled_count();
        int n;
        n = int'(set_enabled);
        if (n < 1) n = 1;
        if (n > iac_pkg::NUM_CODES_DEFAULT) n = iac_pkg::NUM_CODES_DEFAULT;
        if (n > iac_pkg::CODE_REGS) n = iac_pkg::CODE_REGS;
        return n;
    endfunction

    function automatic bit code_valid(int value);
        int  i;
        bit  hit;
        hit = 1'b0;
        for (i = 0; i < enabled_count(); i++) begin
            if (set_codes[i] == value) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic bit is_digit(logic [7:0] ch);
        return ch >= iac_pkg::ASCII_ZERO && ch <= iac_pkg::ASCII_NINE;
    endfunction

    // Feed one character to the code collector; true when a valid code completes.
    function automatic bit take_key(logic [7:0] ch);
        int v;
        if (is_digit(ch)) begin
            v = code_sum * 10 + int'(ch - iac_pkg::ASCII_ZERO);
            if (code_len >= 3) begin
                code_sum = 0;
                code_len = 0;
                return code_valid(v);
            end
            code_sum = v & 'h3FFF;
            code_len = (code_len + 1) & 3;
            return 1'b0;
        end
        code_sum = 0;
        code_len = 0;
        return 1'b0;
    endfunction

    // Outside the wait mode only digits and hash reach the collector.
    function automatic bit keypad_code_ok(tick_t t);
        if (!t.present) return 1'b0;
        if (is_digit(t.key) || t.key == iac_pkg::ASCII_HASH) return take_key(t.key);
        return 1'b0;
    endfunction

    // Advance the predicted panel by one tick and return the status it reports.
    function automatic status_t advance_panel(tick_t t);
        status_t     s;
        logic [2:0]  nxt;
        logic [2:0]  msg;
        bit          upd;
        bit          hot;
        bit          entering;
        int          secs;
        hot = t.temp >= set_threshold;
        nxt = panel_mode;
        msg = iac_pkg::MSG_NONE;
        upd = 1'b0;
        secs = 0;
        entering = 1'b0;
        case (panel_mode)
            iac_pkg::MODE_ARMING: begin
                if (panel_count != 0 && panel_count % 1000 == 0) begin
                    upd = 1'b1;
                    secs = panel_count / 1000;
                end
                if (keypad_code_ok(t)) begin
                    nxt = iac_pkg::MODE_WAIT;
                    msg = iac_pkg::MSG_PROMPT;
                end else if (panel_count <= 1) begin
                    panel_count = '0;
                    nxt = iac_pkg::MODE_ARMED;
                    msg = iac_pkg::MSG_ARMED;
                end else begin
                    panel_count = panel_count - 1'b1;
                end
            end
            iac_pkg::MODE_ARMED: begin
                // A digit or hash key takes precedence over the switches.
                if (t.present && (is_digit(t.key) || t.key == iac_pkg::ASCII_HASH)) begin
                    if (take_key(t.key)) begin
                        nxt = iac_pkg::MODE_WAIT;
                        msg = iac_pkg::MSG_PROMPT;
                    end
                end else if (t.switches[0]) begin
                    nxt = iac_pkg::MODE_ENTRY;
                    msg = iac_pkg::MSG_DISARMING;
                    panel_count = set_delay;
                    entering = 1'b1;
                end else if (t.switches[7:1] != '0) begin
                    nxt = iac_pkg::MODE_ALARM;
                    msg = iac_pkg::MSG_NONE;
                end
                if (!entering && hot) begin
                    nxt = iac_pkg::MODE_ALARM;
                    msg = iac_pkg::MSG_NONE;
                end
            end
            iac_pkg::MODE_ENTRY: begin
                if (panel_count % 1000 == 0) begin
                    upd = 1'b1;
                    secs = panel_count / 1000;
                end
                if (panel_count == 0) begin
                    nxt = iac_pkg::MODE_ALARM;
                end else if (keypad_code_ok(t)) begin
                    if (hot) begin
                        nxt = iac_pkg::MODE_ALARM;
                    end else begin
                        nxt = iac_pkg::MODE_WAIT;
                        msg = iac_pkg::MSG_PROMPT;
                    end
                end else begin
                    panel_count = panel_count - 1'b1;
                end
            end
            iac_pkg::MODE_ALARM: begin
                if (keypad_code_ok(t)) begin
                    nxt = iac_pkg::MODE_WAIT;
                    msg = iac_pkg::MSG_PROMPT;
                end
            end
            default: begin
                // In wait every key reaches the collector, so any non-digit clears it.
                if (t.present && take_key(t.key)) begin
                    nxt = iac_pkg::MODE_ARMING;
                    msg = iac_pkg::MSG_ARMING;
                    panel_count = set_delay;
                end else begin
                    nxt = iac_pkg::MODE_WAIT;
                end
            end
        endcase
        panel_mode = nxt;
        mode_visits[nxt]++;
        s.mode = nxt;
        s.siren = (nxt == iac_pkg::MODE_ALARM);
        s.msg = msg;
        s.upd = upd;
        s.secs = upd ? 7'(secs) : 7'd0;
        s.shown = !(nxt == iac_pkg::MODE_ARMING || nxt == iac_pkg::MODE_ENTRY);
        return s;
    endfunction

    function automatic logic [7:0] calm_temp();
        if (set_threshold == 0) return 8'd0;
        return 8'($urandom_range(0, set_threshold - 1));
    endfunction

    function automatic tick_t make_tick(logic present, logic [7:0] key, logic [7:0] sw,
                                        logic [7:0] temp);
        tick_t t;
        t.present = present;
        t.key = key;
        t.switches = sw;
        t.temp = temp;
        return t;
    endfunction

    function automatic tick_t quiet_tick();
        return make_tick(1'b0, 8'($urandom), 8'h00, calm_temp());
    endfunction

    // Send one tick request after a random gap and record the status it must produce.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = t.present;
        s_tdata = {t.temp, t.switches, t.key};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(advance_panel(t));
        ticks_sent++;
    endtask

    // Enter a four digit code, optionally with empty ticks between the keys.
    task automatic send_code(input int code, input logic [7:0] temp, input bit spread);
        int  k;
        int  scale;
        scale = 1000;
        for (k = 0; k < 4; k++) begin
            if (spread) repeat ($urandom_range(0, 2)) send_tick(quiet_tick());
            send_tick(make_tick(1'b1, 8'(iac_pkg::ASCII_ZERO + (code / scale) % 10),
                                8'h00, temp));
            scale = scale / 10;
        end
    endtask

    // Let every outstanding result drain before touching the settings or ending.
    task automatic settle_block();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register over APB, then read it back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        case (idx)
            iac_pkg::REG_DELAY_TICKS:   mask = 32'h0000_FFFF;
            iac_pkg::REG_HIGH_TEMP:     mask = 32'h0000_00FF;
            iac_pkg::REG_CODES_ENABLED: mask = 32'h0000_0007;
            default:                    mask = 32'h0000_3FFF;
        endcase
        settle_block();
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        reg_writes++;
        case (idx)
            iac_pkg::REG_DELAY_TICKS:   set_delay = value[15:0];
            iac_pkg::REG_HIGH_TEMP:     set_threshold = value[7:0];
            iac_pkg::REG_CODES_ENABLED: set_enabled = value[2:0];
            default: set_codes[2'(idx - iac_pkg::REG_CODE_ZERO)] = value[13:0];
        endcase
        if (readback !== (value & mask)) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("tb: register %0d read back %h, expected %h",
                         idx, readback, value & mask);
        end
    endtask

    // Result side: random stalls, then each status is compared with the oldest prediction.
    initial begin : status_monitor
        status_t got;
        status_t want;
        int      stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata;
            results_seen++;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("tb: status %h arrived with no tick outstanding", got);
            end else begin
                want = pending_status.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"tb: status %0d mismatch: expected mode %0d siren %0d ",
                                  "msg %0d upd %0d secs %0d shown %0d, got mode %0d ",
                                  "siren %0d msg %0d upd %0d secs %0d shown %0d"},
                                 results_seen, want.mode, want.siren, want.msg, want.upd,
                                 want.secs, want.shown, got.mode, got.siren, got.msg,
                                 got.upd, got.secs, got.shown);
                end
            end
        end
    end

    // Reset settings: a non-digit clears a partial code, the first arming second shows,
    // and hash clears the collector during the countdown.
    task automatic test_reset_settings();
        send_tick(make_tick(1'b1, "1", 8'h00, calm_temp()));
        send_tick(make_tick(1'b1, "2", 8'h00, calm_temp()));
        send_tick(make_tick(1'b1, "A", 8'h00, calm_temp()));
        send_code(0, calm_temp(), 1'b0);
        send_tick(quiet_tick());
        send_tick(make_tick(1'b1, "5", 8'h00, calm_temp()));
        send_tick(make_tick(1'b1, iac_pkg::ASCII_HASH, 8'h00, calm_temp()));
        send_code(0, calm_temp(), 1'b0);
    endtask

    // Armed panel: an unrelated key is ignored and a window switch sounds the alarm.
    task automatic test_intrusion();
        send_code(4321, calm_temp(), 1'b0);
        send_tick(quiet_tick());
        send_tick(make_tick(1'b1, "x", 8'h80, calm_temp()));
        send_code(9999, calm_temp(), 1'b0);
    endtask

    // Entry delay: the seconds boundary, a valid code while hot, and running out to zero.
    task automatic test_entry_delay();
        send_code(1234, calm_temp(), 1'b0);
        send_tick(quiet_tick());
        write_reg(iac_pkg::REG_DELAY_TICKS, 32'd1000);
        send_tick(make_tick(1'b0, 8'($urandom), 8'h01, calm_temp()));
        send_tick(quiet_tick());
        send_code(0, 8'hFF, 1'b0);
        send_code(0, calm_temp(), 1'b0);
        write_reg(iac_pkg::REG_DELAY_TICKS, 32'd1);
        send_code(9999, calm_temp(), 1'b0);
        send_tick(quiet_tick());
        send_tick(make_tick(1'b0, 8'($urandom), 8'h03, calm_temp()));
        send_tick(quiet_tick());
        send_tick(quiet_tick());
        send_code(4321, calm_temp(), 1'b0);
    endtask

    // One random phase under fresh settings: mostly code entry and quiet runs so the
    // panel gets through arming, with switch events, hot samples and noise mixed in.
    task automatic run_random_phase(input int count, input logic [15:0] delay,
                                    input logic [7:0] threshold, input logic [2:0] enabled,
                                    input bit extreme_codes);
        int          start;
        int          roll;
        int          code;
        logic [7:0]  junk;
        logic [7:0]  sw;
        write_reg(iac_pkg::REG_DELAY_TICKS, 32'(delay));
        write_reg(iac_pkg::REG_HIGH_TEMP, 32'(threshold));
        write_reg(iac_pkg::REG_CODE_ZERO, extreme_codes ? 0 : $urandom_range(0, 9999));
        write_reg(iac_pkg::REG_CODE_ONE, extreme_codes ? 9999 : $urandom_range(0, 9999));
        write_reg(iac_pkg::REG_CODE_TWO, $urandom_range(0, 9999));
        write_reg(iac_pkg::REG_CODE_THREE, $urandom_range(0, 9999));
        write_reg(iac_pkg::REG_CODES_ENABLED, 32'(enabled));
        start = ticks_sent;
        while (ticks_sent - start < count) begin
            steady = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                if ($urandom_range(0, 99) < 70)
                    code = int'(set_codes[$urandom_range(0, enabled_count() - 1)]);
                else
                    code = $urandom_range(0, 9999);
                // Sometimes a broken attempt comes first.
                if ($urandom_range(0, 99) < 15) begin
                    repeat ($urandom_range(1, 3))
                        send_tick(make_tick(1'b1,
                                            8'(iac_pkg::ASCII_ZERO + $urandom_range(0, 9)),
                                            8'h00, calm_temp()));
                    do junk = 8'($urandom); while (is_digit(junk));
                    if ($urandom_range(0, 1)) junk = iac_pkg::ASCII_HASH;
                    send_tick(make_tick(1'b1, junk, 8'h00, calm_temp()));
                end
                send_code(code, calm_temp(), 1'b1);
            end else if (roll < 65) begin
                repeat ($urandom_range(1, 15)) send_tick(quiet_tick());
            end else if (roll < 78) begin
                sw = $urandom_range(0, 1) ? 8'h01 : 8'($urandom_range(1, 255));
                send_tick(make_tick(1'b0, 8'($urandom), sw, calm_temp()));
            end else if (roll < 86) begin
                send_tick(make_tick(1'b0, 8'($urandom), 8'h00,
                                    8'($urandom_range(threshold, 255))));
            end else begin
                send_tick(make_tick(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
            end
        end
        steady = 1'b0;
    endtask

    // Main sequence.
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        cycle_count = 0;
        ticks_sent = 0;
        reg_writes = 0;
        results_seen = 0;
        mismatches = 0;
        mode_visits = '{default: 0};
        panel_mode = iac_pkg::MODE_WAIT;
        panel_count = '0;
        code_sum = 0;
        code_len = 0;
        set_delay = iac_pkg::DELAY_TICKS_RESET;
        set_threshold = iac_pkg::HIGH_TEMP_RESET;
        set_codes = '{default: '0};
        set_enabled = iac_pkg::CODES_ENABLED_RESET;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();

        write_reg(iac_pkg::REG_DELAY_TICKS, 32'd1);
        write_reg(iac_pkg::REG_HIGH_TEMP, 32'd255);
        write_reg(iac_pkg::REG_CODE_ZERO, 32'd9999);
        write_reg(iac_pkg::REG_CODE_ONE, 32'd1234);
        write_reg(iac_pkg::REG_CODE_TWO, 32'd0);
        write_reg(iac_pkg::REG_CODE_THREE, 32'd4321);
        write_reg(iac_pkg::REG_CODES_ENABLED, 32'd4);
        test_intrusion();
        test_entry_delay();

        run_random_phase(90, 16'd3, 8'd40, 3'd2, 1'b0);
        run_random_phase(90, 16'd0, 8'd255, 3'd0, 1'b1);
        run_random_phase(60, 16'd1, 8'd0, 3'd7, 1'b0);
        run_random_phase(60, 16'd1002, 8'($urandom_range(20, 60)), 3'd3, 1'b0);
        run_random_phase(40, 16'd65535, 8'd30, 3'd4, 1'b1);
        run_random_phase(40, 16'($urandom_range(2, 12)), 8'($urandom_range(10, 80)),
                         3'($urandom_range(1, 4)), 1'b0);

        settle_block();
        $display({"tb: %0d tick requests, %0d register writes, ",
                  "%0d statuses checked, %0d mismatches"},
                 ticks_sent, reg_writes, results_seen, mismatches);
        $display("tb: ticks ending in wait %0d, arming %0d, armed %0d, entry delay %0d, alarm %0d",
                 mode_visits[0], mode_visits[1], mode_visits[2], mode_visits[3],
                 mode_visits[4]);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: intrusion_alarm_controller.f
rtl/iac_pkg.sv
rtl/intrusion_alarm_controller.sv
dv/tb.sv
